FILE: hw/rtl/u8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 decoder
// Status codes, field widths and the record that the front end hands to the
// back end through the decoupling queue.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ST_W   = 3;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CONT = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OVERLONG = 3'd4
  } status_t;

  // One record per input word that causes output. pre_err asks for a
  // bad-continuation result ahead of the main one; has_main says that a
  // main result (cp, status) follows.
  typedef struct packed {
    logic    pre_err;
    logic    has_main;
    cp_t     cp;
    status_t status;
  } u8d_rec_t;

  localparam int unsigned REC_W = $bits(u8d_rec_t);

endpackage : u8d_pkg
`default_nettype wire

FILE: hw/rtl/u8d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_front: byte classifier and sequence tracker
// Holds the open-sequence state, decodes one byte per cycle while take is high and
// produces a record describing the results that the byte causes.
// ----------------------------------------------------------------------------
module u8d_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 take,        // word accepted this cycle
  input  wire u8d_pkg::byte_t data_byte,
  input  wire                 end_mark,
  output logic                rec_valid,   // the word produces a record
  output u8d_pkg::u8d_rec_t   rec
);
  import u8d_pkg::*;

  logic [1:0] pending_r, pending_nxt;
  logic [1:0] extra_r,   extra_nxt;
  cp_t        acc_r,     acc_nxt;

  cp_t        cont_val;
  logic       is_cont;
  status_t    chk_st;

  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign cont_val = {acc_r[CP_W-7:0], data_byte[5:0]};

  // Range and surrogate checks win over the overlong check.
  always_comb begin
    chk_st = ST_OK;
    if ((cont_val > 21'h10FFFF) || ((cont_val >= 21'h00D800) && (cont_val < 21'h00E000))) begin
      chk_st = ST_RANGE;
    end else if (((extra_r == 2'd1) && (cont_val < 21'h000080)) ||
                 ((extra_r == 2'd2) && (cont_val < 21'h000800)) ||
                 ((extra_r == 2'd3) && (cont_val < 21'h010000))) begin
      chk_st = ST_OVERLONG;
    end
  end

  always_comb begin
    logic lead;
    lead        = 1'b0;
    pending_nxt = pending_r;
    extra_nxt   = extra_r;
    acc_nxt     = acc_r;
    rec         = '{pre_err: 1'b0, has_main: 1'b0, cp: '0, status: ST_OK};

    if (end_mark) begin
      rec.pre_err = (pending_r != 2'd0);
      pending_nxt = 2'd0;
      extra_nxt   = 2'd0;
      acc_nxt     = '0;
    end else if (pending_r != 2'd0) begin
      if (is_cont) begin
        if (pending_r == 2'd1) begin
          rec.has_main = 1'b1;
          rec.status   = chk_st;
          rec.cp       = (chk_st == ST_OK) ? cont_val : '0;
          pending_nxt  = 2'd0;
          extra_nxt    = 2'd0;
          acc_nxt      = '0;
        end else begin
          pending_nxt = pending_r - 2'd1;
          acc_nxt     = cont_val;
        end
      end else begin
        // The open sequence is dropped and this byte starts over as a lead.
        rec.pre_err = 1'b1;
        pending_nxt = 2'd0;
        extra_nxt   = 2'd0;
        acc_nxt     = '0;
        lead        = 1'b1;
      end
    end else begin
      lead = 1'b1;
    end

    if (lead) begin
      if (!data_byte[7]) begin
        rec.has_main = 1'b1;
        rec.cp       = {{(CP_W-BYTE_W){1'b0}}, data_byte};
      end else if (data_byte[7:5] == 3'b110) begin
        acc_nxt     = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        pending_nxt = 2'd1;
        extra_nxt   = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        acc_nxt     = {{(CP_W-4){1'b0}}, data_byte[3:0]};
        pending_nxt = 2'd2;
        extra_nxt   = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
        acc_nxt     = {{(CP_W-3){1'b0}}, data_byte[2:0]};
        pending_nxt = 2'd3;
        extra_nxt   = 2'd3;
      end else begin
        rec.has_main = 1'b1;
        rec.status   = ST_BAD_LEAD;
      end
    end
  end

  assign rec_valid = take && (rec.pre_err || rec.has_main);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      extra_r   <= 2'd0;
      acc_r     <= '0;
    end else if (take) begin
      pending_r <= pending_nxt;
      extra_r   <= extra_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule : u8d_front
`default_nettype wire

FILE: hw/rtl/u8d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_queue: record queue between front and back end
// A small first-in first-out store of decode records with a head that is
// visible without a read cycle.
// ----------------------------------------------------------------------------
module u8d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   wr_en,
  input  wire u8d_pkg::u8d_rec_t wr_rec,
  output logic                  q_full,
  input  wire                   rd_en,
  output u8d_pkg::u8d_rec_t     rd_rec,
  output logic                  q_empty
);
  import u8d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u8d_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == FULL_CNT);
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_rec  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule : u8d_queue
`default_nettype wire

FILE: hw/rtl/u8d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_back: result sequencer and output register
// Expands each record into one or two result words and holds the oldest
// result in an output register until it is popped.
// ----------------------------------------------------------------------------
module u8d_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire u8d_pkg::u8d_rec_t rec,
  input  wire                    rec_empty,
  output logic                   rec_pop,
  output logic                   empty,
  input  wire                    pop,
  output u8d_pkg::cp_t           code_point,
  output logic [2:0]             status,
  output logic                   last_of_run
);
  import u8d_pkg::*;

  logic    out_valid_r;
  cp_t     cp_r;
  status_t st_r;
  logic    last_r;
  logic    phase_r;      // 1: the leading error word of the head record is out
  logic    load;
  logic    lead_word;    // the word to load is the leading error word

  assign load      = !rec_empty && (!out_valid_r || pop);
  assign lead_word = rec.pre_err && !phase_r;
  // A record leaves the queue with its final word.
  assign rec_pop   = load && !(lead_word && rec.has_main);

  always_ff @(posedge clk) begin
    if (load) begin
      if (lead_word) begin
        cp_r   <= '0;
        st_r   <= ST_BAD_CONT;
        last_r <= !rec.has_main;
      end else begin
        cp_r   <= rec.cp;
        st_r   <= rec.status;
        last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= lead_word && rec.has_main;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty       = !out_valid_r;
  assign code_point  = cp_r;
  assign status      = st_r;
  assign last_of_run = last_r;

endmodule : u8d_back
`default_nettype wire

FILE: hw/rtl/utf8_code_point_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_code_point_decoder: UTF-8 decoder with validation
// Turns a byte stream into code points and error status words.
// ----------------------------------------------------------------------------
// The block takes one byte word per clock while full is low and returns one
// result word for every completed or failed UTF-8 sequence. ASCII bytes come
// straight out as code points. A lead byte opens a sequence of one to three
// continuation bytes; the finished value is checked for range and surrogates
// first and for overlong form second. Every error word carries code point 0
// and a nonzero status. A byte that breaks an open sequence gives a
// bad-continuation word and is then decoded again as a lead byte, so one input
// byte can cause two result words; last_of_run marks the final word of each
// input byte. An end mark closes an open sequence with a bad-continuation
// word and is otherwise silent. A word that a byte causes is written into the
// record queue when the byte is accepted and is registered into the output
// register after that, once the output register is free. The front end accepts
// one byte every cycle while full is low; the output register drains one word
// per cycle while pop is high, so a byte that causes two words costs an extra
// output word slot, which the record queue of QUEUE_DEPTH entries absorbs.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // Input word channel.
  input  wire                 push,
  output logic                full,
  input  wire u8d_pkg::byte_t in_data_byte,
  input  wire                 in_end_mark,
  // Result word channel.
  output logic                empty,
  input  wire                 pop,
  output u8d_pkg::cp_t        out_code_point,
  output logic [2:0]          out_status,
  output logic                out_last_of_run
);
  import u8d_pkg::*;

  logic     take;
  logic     rec_valid;
  u8d_rec_t front_rec;
  u8d_rec_t head_rec;
  logic     q_empty;
  logic     q_pop;

  // The front end runs only when the queue can take whatever this byte makes.
  assign take = push && !full;

  u8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .end_mark  (in_end_mark),
    .rec_valid (rec_valid),
    .rec       (front_rec)
  );

  // Records sit here until the back end has loaded all of their words.
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_valid),
    .wr_rec  (front_rec),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_rec  (head_rec),
    .q_empty (q_empty)
  );

  // The back end splits a record into its words and owns the output register.
  u8d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec         (head_rec),
    .rec_empty   (q_empty),
    .rec_pop     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .code_point  (out_code_point),
    .status      (out_status),
    .last_of_run (out_last_of_run)
  );

endmodule : utf8_code_point_decoder
`default_nettype wire

FILE: hw/rtl/u8d_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_checker: port-level checks of the UTF-8 decoder
// Watches the result channel for status coding and handshake behavior.
// ----------------------------------------------------------------------------
module u8d_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        empty,
  input wire        pop,
  input wire [20:0] out_code_point,
  input wire [2:0]  out_status,
  input wire        out_last_of_run
);
  import u8d_pkg::*;

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result channel not empty after reset");

  // Error words always carry code point zero.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status != ST_OK)) |-> (out_code_point == '0))
    else $error("error word with nonzero code point");

  // Only a bad-continuation word can be followed by another word of its run.
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last_of_run) |-> (out_status == ST_BAD_CONT))
    else $error("non-final word that is not a bad-continuation error");

  // Status stays within its defined codes and ok values stay in range.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_status == ST_OK) || (out_status == ST_BAD_LEAD) ||
                (out_status == ST_BAD_CONT) || (out_status == ST_RANGE) ||
                (out_status == ST_OVERLONG)) && (out_code_point <= 21'h10FFFF))
    else $error("undefined status or out-of-range code point");

  // A waiting word holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_code_point) && $stable(out_status) &&
                          $stable(out_last_of_run)))
    else $error("waiting result word changed before pop");

endmodule : u8d_checker

bind utf8_code_point_decoder u8d_checker u_u8d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_code_point  (out_code_point),
  .out_status      (out_status),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire
